// ===== src/hrq_pkg.sv =====
// Shared types and constants of the response-ratio ready queue.
// Used by the ratio unit, the sequencer, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrq_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_JOBS_DEF  = 16;
   localparam int TIME_BITS_DEF = 16;

   // Fixed field widths of the stream payloads.
   localparam int FIELD_W     = 16;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Stream payload layout.
   localparam int REQ_TDATA_W = 5 * FIELD_W;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_CNT_LSB = 4 * FIELD_W;

   // Command codes; any code other than the first two selects a ratio dequeue.
   localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ_HEAD = 2'd1;

   // Status codes of a result transaction.
   localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   // Strobes from the sequencer to the ratio unit.
   typedef struct packed {
      logic load;    // capture waiting and remaining time of the read record
      logic mul;     // form both cross products
      logic take;    // compare and keep the winner
      logic first;   // first record of the scan wins unconditionally
   } ratio_ctl_type;

endpackage

`default_nettype wire

// ===== src/hrq_store.sv =====
// Record and link memories of the ready queue, one shared read address.
// Depends on nothing but its parameters; read data is registered.
`timescale 1ns / 1ps
`default_nettype none

module hrq_store #(
   parameter int SLOTS  = 16,
   parameter int SLOT_W = 4,
   parameter int REC_W  = 64
) (
   input  wire logic              clock,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output logic      [REC_W-1:0]  rec_rdata,
   output logic      [SLOT_W-1:0] link_rdata,
   input  wire logic              rec_we,
   input  wire logic [SLOT_W-1:0] rec_waddr,
   input  wire logic [REC_W-1:0]  rec_wdata,
   input  wire logic              link_we,
   input  wire logic [SLOT_W-1:0] link_waddr,
   input  wire logic [SLOT_W-1:0] link_wdata
);

   logic [REC_W-1:0]  rec_mem  [SLOTS];
   logic [SLOT_W-1:0] link_mem [SLOTS];
   logic [REC_W-1:0]  rec_rdata_ff;
   logic [SLOT_W-1:0] link_rdata_ff;

   // Job records: job id and the three times of each slot.
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_rdata_ff <= rec_mem[rd_addr];
   end

   // Next-slot links; queue order and the free list both thread through here.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata_ff <= link_mem[rd_addr];
   end

   assign rec_rdata  = rec_rdata_ff;
   assign link_rdata = link_rdata_ff;

endmodule

`default_nettype wire

// ===== src/hrq_ratio.sv =====
// Response ratio unit: waiting time, signed cross products and comparison.
// Depends on hrq_pkg for the strobe struct and the field width; one product pair per record.
`timescale 1ns / 1ps
`default_nettype none

module hrq_ratio #(
   parameter int TIME_BITS = hrq_pkg::TIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire hrq_pkg::ratio_ctl_type ctl,
   input  wire logic [((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] now,
   input  wire logic [((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] arr,
   input  wire logic [((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] svc,
   input  wire logic [((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] rem,
   output logic                        replace
);

   import hrq_pkg::*;

   localparam int TW = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
   localparam int WW = TW + 3;     // signed waiting time
   localparam int RW = TW + 1;     // remaining time as a positive signed value
   localparam int PW = WW + RW;    // exact cross product

   logic signed [WW-1:0] w_in, w_ff, bw_ff;
   logic signed [RW-1:0] r_in, r_ff, br_ff;
   logic signed [PW-1:0] pa_in, pa_ff, pb_in, pb_ff;

   // Waiting time is now - arrival - service + remaining, exact in WW bits.
   always_comb begin
      w_in = $signed({3'b000, now}) - $signed({3'b000, arr})
           - $signed({3'b000, svc}) + $signed({3'b000, rem});
      r_in = $signed({1'b0, rem});
   end

   // Candidate ratio w/r beats the best bw/br when w*br >= bw*r; ties go to
   // the later record.
   always_comb begin
      pa_in = w_ff * br_ff;
      pb_in = bw_ff * r_ff;
   end

   assign replace = ctl.first || (pa_ff >= pb_ff);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         w_ff <= w_in;
         r_ff <= r_in;
      end
      if (ctl.mul) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (ctl.take && replace) begin
         bw_ff <= w_ff;
         br_ff <= r_ff;
      end
   end

endmodule

`default_nettype wire

// ===== src/hrq_ctrl.sv =====
// Command sequencer of the ready queue: enqueue, unlink and ratio scan.
// Depends on hrq_pkg; drives the memories in hrq_store and the hrq_ratio unit.
`timescale 1ns / 1ps
`default_nettype none

module hrq_ctrl #(
   parameter int MAX_JOBS  = hrq_pkg::MAX_JOBS_DEF,
   parameter int TIME_BITS = hrq_pkg::TIME_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request side
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [hrq_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [hrq_pkg::FIELD_W-1:0]    req_id,
   input  wire logic [hrq_pkg::FIELD_W-1:0]    req_arr,
   input  wire logic [hrq_pkg::FIELD_W-1:0]    req_svc,
   input  wire logic [hrq_pkg::FIELD_W-1:0]    req_rem,
   input  wire logic [hrq_pkg::FIELD_W-1:0]    req_now,
   // Memory ports
   output logic [$clog2(MAX_JOBS)-1:0]         rd_addr,
   input  wire logic [hrq_pkg::FIELD_W+3*((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] rec_rdata,
   input  wire logic [$clog2(MAX_JOBS)-1:0]    link_rdata,
   output logic                                rec_we,
   output logic [$clog2(MAX_JOBS)-1:0]         rec_waddr,
   output logic [hrq_pkg::FIELD_W+3*((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] rec_wdata,
   output logic                                link_we,
   output logic [$clog2(MAX_JOBS)-1:0]         link_waddr,
   output logic [$clog2(MAX_JOBS)-1:0]         link_wdata,
   // Ratio unit
   output hrq_pkg::ratio_ctl_type              ratio_ctl,
   output logic [((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] ratio_now,
   input  wire logic                           replace,
   // Result side
   output logic                                res_valid,
   input  wire logic                           res_ready,
   output logic [hrq_pkg::STATUS_W-1:0]        res_status,
   output logic [hrq_pkg::FIELD_W-1:0]         res_id,
   output logic [((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] res_arr,
   output logic [((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] res_svc,
   output logic [((TIME_BITS < hrq_pkg::FIELD_W) ? TIME_BITS : hrq_pkg::FIELD_W)-1:0] res_rem,
   output logic [$clog2(MAX_JOBS+1)-1:0]       res_count
);

   import hrq_pkg::*;

   localparam int TW     = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
   localparam int SLOT_W = $clog2(MAX_JOBS);
   localparam int CW     = $clog2(MAX_JOBS + 1);
   localparam int REC_W  = FIELD_W + 3 * TW;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_JOBS);
   localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENQ_WR,
      S_SCAN_LOAD,
      S_SCAN_MUL,
      S_SCAN_CMP,
      S_UNL_RD,
      S_UNL_LINK,
      S_UNL_FREE,
      S_RESP
   } state_type;

   // Control state (reset)
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic [CW-1:0]     fresh_ff, fresh_in;
   logic [CW-1:0]     held_ff, held_in;

   // Working registers of one command (no reset)
   logic [CW-1:0]     left_ff, left_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] prev_ff, prev_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [SLOT_W-1:0] nxt_ff, nxt_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic [SLOT_W-1:0] best_prev_ff, best_prev_in;
   logic              best_has_prev_ff, best_has_prev_in;
   logic              first_ff, first_in;
   logic [FIELD_W-1:0] id_ff, id_in;
   logic [TW-1:0]     arr_ff, arr_in;
   logic [TW-1:0]     svc_ff, svc_in;
   logic [TW-1:0]     rem_ff, rem_in;
   logic [TW-1:0]     now_ff, now_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [FIELD_W-1:0] res_id_ff, res_id_in;
   logic [TW-1:0]     res_arr_ff, res_arr_in;
   logic [TW-1:0]     res_svc_ff, res_svc_in;
   logic [TW-1:0]     res_rem_ff, res_rem_in;

   logic              accept;
   logic              use_fresh;
   logic [SLOT_W-1:0] new_slot;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign use_fresh = (fresh_ff != FULL_COUNT);
   // Never-used slots go first; once all were used, pop the free list.
   assign new_slot  = use_fresh ? fresh_ff[SLOT_W-1:0] : free_head_ff;

   // Memory read address: each state reads what the next state consumes.
   always_comb begin
      case (state_ff)
         S_IDLE:     rd_addr = (req_cmd == CMD_ENQUEUE) ? free_head_ff : head_ff;
         S_SCAN_CMP: rd_addr = nxt_ff;
         S_UNL_RD:   rd_addr = best_ff;
         default:    rd_addr = head_ff;
      endcase
   end

   // Memory writes: record on enqueue, links on enqueue and unlink.
   always_comb begin
      rec_we     = (state_ff == S_ENQ_WR);
      rec_waddr  = new_slot;
      rec_wdata  = {rem_ff, svc_ff, arr_ff, id_ff};
      link_we    = 1'b0;
      link_waddr = tail_ff;
      link_wdata = new_slot;
      case (state_ff)
         S_ENQ_WR: begin
            link_we    = (held_ff != '0);
            link_waddr = tail_ff;
            link_wdata = new_slot;
         end
         S_UNL_LINK: begin
            link_we    = best_has_prev_ff;
            link_waddr = best_prev_ff;
            link_wdata = link_rdata;
         end
         S_UNL_FREE: begin
            link_we    = 1'b1;
            link_waddr = best_ff;
            link_wdata = free_head_ff;
         end
         default: begin
            link_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      ratio_ctl.load  = (state_ff == S_SCAN_LOAD);
      ratio_ctl.mul   = (state_ff == S_SCAN_MUL);
      ratio_ctl.take  = (state_ff == S_SCAN_CMP);
      ratio_ctl.first = first_ff;
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      free_head_in     = free_head_ff;
      fresh_in         = fresh_ff;
      held_in          = held_ff;
      left_in          = left_ff;
      cur_in           = cur_ff;
      prev_in          = prev_ff;
      prev_valid_in    = prev_valid_ff;
      nxt_in           = nxt_ff;
      best_in          = best_ff;
      best_prev_in     = best_prev_ff;
      best_has_prev_in = best_has_prev_ff;
      first_in         = first_ff;
      id_in            = id_ff;
      arr_in           = arr_ff;
      svc_in           = svc_ff;
      rem_in           = rem_ff;
      now_in           = now_ff;
      status_in        = status_ff;
      res_id_in        = res_id_ff;
      res_arr_in       = res_arr_ff;
      res_svc_in       = res_svc_ff;
      res_rem_in       = res_rem_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // Capture the transaction; a zero remaining time becomes one.
               id_in      = req_id;
               arr_in     = req_arr[TW-1:0];
               svc_in     = req_svc[TW-1:0];
               rem_in     = (req_rem[TW-1:0] == '0) ? TW'(1) : req_rem[TW-1:0];
               now_in     = req_now[TW-1:0];
               res_id_in  = '0;
               res_arr_in = '0;
               res_svc_in = '0;
               res_rem_in = '0;
               if (req_cmd == CMD_ENQUEUE) begin
                  if (held_ff == FULL_COUNT) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_ENQ_WR;
                  end
               end else if (held_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_RESP;
               end else if (req_cmd == CMD_DEQ_HEAD) begin
                  best_in          = head_ff;
                  best_has_prev_in = 1'b0;
                  state_in         = S_UNL_LINK;
               end else begin
                  cur_in        = head_ff;
                  prev_valid_in = 1'b0;
                  first_in      = 1'b1;
                  left_in       = held_ff - ONE_COUNT;
                  state_in      = S_SCAN_LOAD;
               end
            end
         end

         S_ENQ_WR: begin
            // Link data read in the idle cycle is the free list successor.
            if (use_fresh) begin
               fresh_in = fresh_ff + ONE_COUNT;
            end else begin
               free_head_in = link_rdata;
            end
            if (held_ff == '0) begin
               head_in = new_slot;
            end
            tail_in   = new_slot;
            held_in   = held_ff + ONE_COUNT;
            status_in = ST_ENQUEUED;
            state_in  = S_RESP;
         end

         S_SCAN_LOAD: begin
            nxt_in   = link_rdata;
            state_in = S_SCAN_MUL;
         end

         S_SCAN_MUL: begin
            state_in = S_SCAN_CMP;
         end

         S_SCAN_CMP: begin
            if (replace) begin
               best_in          = cur_ff;
               best_prev_in     = prev_ff;
               best_has_prev_in = prev_valid_ff;
            end
            prev_in       = cur_ff;
            prev_valid_in = 1'b1;
            cur_in        = nxt_ff;
            first_in      = 1'b0;
            left_in       = left_ff - ONE_COUNT;
            state_in      = (left_ff == '0) ? S_UNL_RD : S_SCAN_LOAD;
         end

         S_UNL_RD: begin
            state_in = S_UNL_LINK;
         end

         S_UNL_LINK: begin
            // Record of the winner is on the read port; splice it out.
            res_id_in  = rec_rdata[FIELD_W-1:0];
            res_arr_in = rec_rdata[FIELD_W +: TW];
            res_svc_in = rec_rdata[FIELD_W+TW +: TW];
            res_rem_in = rec_rdata[FIELD_W+2*TW +: TW];
            if (!best_has_prev_ff) begin
               head_in = link_rdata;
            end else if (best_ff == tail_ff) begin
               tail_in = best_prev_ff;
            end
            status_in = ST_DEQUEUED;
            state_in  = S_UNL_FREE;
         end

         S_UNL_FREE: begin
            // Push the freed slot on the free list.
            free_head_in = best_ff;
            held_in      = held_ff - ONE_COUNT;
            state_in     = S_RESP;
         end

         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_head_ff <= '0;
         fresh_ff     <= '0;
         held_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         held_ff      <= held_in;
      end
   end

   // Working registers and result payload.
   always_ff @(posedge clock) begin
      left_ff          <= left_in;
      cur_ff           <= cur_in;
      prev_ff          <= prev_in;
      prev_valid_ff    <= prev_valid_in;
      nxt_ff           <= nxt_in;
      best_ff          <= best_in;
      best_prev_ff     <= best_prev_in;
      best_has_prev_ff <= best_has_prev_in;
      first_ff         <= first_in;
      id_ff            <= id_in;
      arr_ff           <= arr_in;
      svc_ff           <= svc_in;
      rem_ff           <= rem_in;
      now_ff           <= now_in;
      status_ff        <= status_in;
      res_id_ff        <= res_id_in;
      res_arr_ff       <= res_arr_in;
      res_svc_ff       <= res_svc_in;
      res_rem_ff       <= res_rem_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign ratio_now  = now_ff;
   assign res_valid  = (state_ff == S_RESP);
   assign res_status = status_ff;
   assign res_id     = res_id_ff;
   assign res_arr    = res_arr_ff;
   assign res_svc    = res_svc_ff;
   assign res_rem    = res_rem_ff;
   assign res_count  = held_ff;

endmodule

`default_nettype wire

// ===== src/hrrn_ready_queue_top.sv =====
// Enqueue writes the record and links it in, then answers; head dequeue unlinks the
// head record and pushes its slot on the free list; ratio dequeue over n held
// records scans them all, reading each record from the record memory and forming
// one pair of cross products per record in the ratio unit, then unlinks the
// winner. Empty or full answers touch no memory. One command is worked at a
// time; a new request is taken while a result waits. Synchronous active-high
// reset empties the queue at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module hrrn_ready_queue_top #(
   parameter int MAX_JOBS  = hrq_pkg::MAX_JOBS_DEF,
   parameter int TIME_BITS = hrq_pkg::TIME_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: job_id, arrival, service_time, remaining_time, current_time
   input  wire logic [hrq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: command
   input  wire logic [hrq_pkg::CMD_W-1:0]        req_tuser,
   // Response stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: out_job_id, out_arrival, out_service_time,
   //        out_remaining_time, queue_count, zero fill
   output logic [hrq_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // tuser: status
   output logic [hrq_pkg::STATUS_W-1:0]          rsp_tuser
);

   import hrq_pkg::*;

   localparam int TW     = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
   localparam int SLOT_W = $clog2(MAX_JOBS);
   localparam int CW     = $clog2(MAX_JOBS + 1);
   localparam int REC_W  = FIELD_W + 3 * TW;
   localparam int PAD_W  = RSP_TDATA_W - 4 * FIELD_W - COUNT_OUT_W;

   logic [SLOT_W-1:0]  rd_addr;
   logic [REC_W-1:0]   rec_rdata;
   logic [SLOT_W-1:0]  link_rdata;
   logic               rec_we;
   logic [SLOT_W-1:0]  rec_waddr;
   logic [REC_W-1:0]   rec_wdata;
   logic               link_we;
   logic [SLOT_W-1:0]  link_waddr;
   logic [SLOT_W-1:0]  link_wdata;
   ratio_ctl_type      ratio_ctl;
   logic [TW-1:0]      ratio_now;
   logic               replace;
   logic               res_valid;
   logic               res_ready;
   logic [STATUS_W-1:0] res_status;
   logic [FIELD_W-1:0] res_id;
   logic [TW-1:0]      res_arr, res_svc, res_rem;
   logic [CW-1:0]      res_count;

   logic [TW+FIELD_W-1:0]     arr_ext, svc_ext, rem_ext;
   logic [CW+COUNT_OUT_W-1:0] cnt_ext;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0]    rsp_tuser_ff, rsp_tuser_in;

   hrq_store #(
      .SLOTS  (MAX_JOBS),
      .SLOT_W (SLOT_W),
      .REC_W  (REC_W)
   ) u_store (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .rec_rdata  (rec_rdata),
      .link_rdata (link_rdata),
      .rec_we     (rec_we),
      .rec_waddr  (rec_waddr),
      .rec_wdata  (rec_wdata),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata)
   );

   hrq_ratio #(
      .TIME_BITS (TIME_BITS)
   ) u_ratio (
      .clock   (clock),
      .ctl     (ratio_ctl),
      .now     (ratio_now),
      .arr     (rec_rdata[FIELD_W +: TW]),
      .svc     (rec_rdata[FIELD_W+TW +: TW]),
      .rem     (rec_rdata[FIELD_W+2*TW +: TW]),
      .replace (replace)
   );

   hrq_ctrl #(
      .MAX_JOBS  (MAX_JOBS),
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_id     (req_tdata[FIELD_W-1:0]),
      .req_arr    (req_tdata[2*FIELD_W-1:FIELD_W]),
      .req_svc    (req_tdata[3*FIELD_W-1:2*FIELD_W]),
      .req_rem    (req_tdata[4*FIELD_W-1:3*FIELD_W]),
      .req_now    (req_tdata[5*FIELD_W-1:4*FIELD_W]),
      .rd_addr    (rd_addr),
      .rec_rdata  (rec_rdata),
      .link_rdata (link_rdata),
      .rec_we     (rec_we),
      .rec_waddr  (rec_waddr),
      .rec_wdata  (rec_wdata),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .ratio_ctl  (ratio_ctl),
      .ratio_now  (ratio_now),
      .replace    (replace),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_status (res_status),
      .res_id     (res_id),
      .res_arr    (res_arr),
      .res_svc    (res_svc),
      .res_rem    (res_rem),
      .res_count  (res_count)
   );

   // Widen the times to the field width; the count is reported modulo 32.
   assign arr_ext = {{FIELD_W{1'b0}}, res_arr};
   assign svc_ext = {{FIELD_W{1'b0}}, res_svc};
   assign rem_ext = {{FIELD_W{1'b0}}, res_rem};
   assign cnt_ext = {{COUNT_OUT_W{1'b0}}, res_count};

   // Output register: the sequencer may start the next command behind it.
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (res_ready) begin
         rsp_tvalid_in = res_valid;
         rsp_tuser_in  = res_status;
         rsp_tdata_in  = {{PAD_W{1'b0}}, cnt_ext[COUNT_OUT_W-1:0],
                          rem_ext[FIELD_W-1:0], svc_ext[FIELD_W-1:0],
                          arr_ext[FIELD_W-1:0], res_id};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ===== src/hrq_checker.sv =====
// Port checker of the ready queue top level, attached by a bind statement.
// Depends on hrq_pkg for status codes and the response layout.
`timescale 1ns / 1ps
`default_nettype none

module hrq_checker #(
   parameter int MAX_JOBS = hrq_pkg::MAX_JOBS_DEF
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [hrq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [hrq_pkg::STATUS_W-1:0]    rsp_tuser
);

   import hrq_pkg::*;

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Only a dequeue carries a record; every other status shows zero fields.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_DEQUEUED) |-> rsp_tdata[RSP_CNT_LSB-1:0] == '0)
      else $error("record fields set on a non-dequeue response");

   // An empty answer leaves the count at zero.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_EMPTY) |->
         rsp_tdata[RSP_CNT_LSB +: COUNT_OUT_W] == '0)
      else $error("empty status with a nonzero count");

   // A full answer shows the queue at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL) |->
         rsp_tdata[RSP_CNT_LSB +: COUNT_OUT_W] == COUNT_OUT_W'(MAX_JOBS))
      else $error("full status below capacity");

endmodule

bind hrrn_ready_queue_top hrq_checker #(
   .MAX_JOBS (MAX_JOBS)
) u_hrq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
